// File: src/cascaded_range_remap_min_assert.svh
// Assertion macros used by the checker file.
`ifndef CASCADED_RANGE_REMAP_MIN_ASSERT_SVH
`define CASCADED_RANGE_REMAP_MIN_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define CRRM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define CRRM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define CRRM_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/crrm_pkg.sv
// Types, constants and opcodes of the cascaded range remap block.
package crrm_pkg;

   localparam int STAGES        = 8;
   localparam int ENTRIES       = 32;
   localparam int VALUE_BITS    = 32;
   localparam int CELL_ID_BITS  = 4;
   localparam int SLOT_BITS     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   typedef logic [VALUE_BITS-1:0] value_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [2:0]  stage_index;
      logic [4:0]  slot_index;
      logic [31:0] dest_start;
      logic [31:0] source_start;
      logic [31:0] range_length;
      logic [31:0] query_value;
   } req_type;

   typedef struct packed {
      logic [31:0] mapped_value;
      logic [31:0] lowest_value;
   } rsp_type;

   // Transaction moving between neighboring cells; query_value carries the
   // value as remapped so far.
   typedef struct packed {
      logic    valid;
      req_type req;
   } link_type;

endpackage

// File: src/cascaded_range_remap_min.sv
// Top level: input register, chain of remap cells, running minimum.
//
//   channel | direction | handshake            | carries
//   req     | in        | req_valid, req_stall | req_type: opcode, load entry, query
//   rsp     | out       | rsp_valid, rsp_stall | rsp_type: mapped and lowest value
//   csr     | in        | csr_valid, csr_ready | stages_in_use, 4 bits
//
// One transaction enters per cycle while req_stall is low; a request passes the
// input register, the match and add registers in each cell and the result
// register before its result shows.
// Loads and clears travel the chain like queries, so each cell sees them in
// request order. Reset is synchronous; slot valid bits clear at once.
// A stalled result freezes the whole chain and raises req_stall.
module cascaded_range_remap_min
   import crrm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_data
);

   logic       advance;
   logic [3:0] stages_ff;
   link_type   head_ff;
   link_type   links [STAGES+1];

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stages_ff     <= 4'd7;
         head_ff.valid <= 1'b0;
      end else begin
         if (csr_valid) begin
            stages_ff <= csr_data;
         end
         if (advance) begin
            head_ff.valid <= req_valid;
            head_ff.req   <= req_data;
         end
      end
   end

   assign links[0] = head_ff;

   for (genvar g = 0; g < STAGES; g++) begin : g_cell
      crrm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_id  (CELL_ID_BITS'(g)),
         .active   (stages_ff > 4'(g)),
         .link_in  (links[g]),
         .link_out (links[g+1])
      );
   end

   crrm_min u_min (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .link_in   (links[STAGES]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: src/crrm_cell.sv
// One remap stage: slot storage, parallel range match, then the offset add.
module crrm_cell
   import crrm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [CELL_ID_BITS-1:0] cell_id,
   input  logic                    active,
   input  link_type                link_in,
   output link_type                link_out
);

   typedef struct packed {
      logic      valid;
      req_type   req;
      logic      hit;
      value_type dest;
      value_type diff;
   } mid_type;

   value_type            dest_ff [ENTRIES];
   value_type            src_ff  [ENTRIES];
   value_type            len_ff  [ENTRIES];
   logic [ENTRIES-1:0]   slot_valid_ff;

   mid_type              mid_ff, mid_in;
   link_type             out_ff, out_in;

   logic                 load_here;
   logic [SLOT_BITS-1:0] slot_addr;

   assign slot_addr = SLOT_BITS'(link_in.req.slot_index);
   assign load_here = link_in.valid && (link_in.req.opcode == OP_LOAD)
                      && (CELL_ID_BITS'(link_in.req.stage_index) == cell_id)
                      && (32'(link_in.req.slot_index) < 32'(ENTRIES));

   // Match every slot at once; the lowest slot that hits wins.
   always_comb begin
      value_type v;
      value_type d;
      logic      found;
      v      = VALUE_BITS'(link_in.req.query_value);
      found  = 1'b0;
      mid_in = '0;
      mid_in.valid = link_in.valid;
      mid_in.req   = link_in.req;
      for (int k = 0; k < ENTRIES; k++) begin
         d = v - src_ff[k];
         if (!found && slot_valid_ff[k] && (v >= src_ff[k]) && (d < len_ff[k])) begin
            found       = 1'b1;
            mid_in.dest = dest_ff[k];
            mid_in.diff = d;
         end
      end
      mid_in.hit = found && active;
   end

   always_comb begin
      value_type sum;
      sum    = mid_ff.dest + mid_ff.diff;
      out_in.valid = mid_ff.valid;
      out_in.req   = mid_ff.req;
      if (mid_ff.hit) begin
         out_in.req.query_value = 32'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         mid_ff.valid  <= 1'b0;
         out_ff.valid  <= 1'b0;
      end else if (advance) begin
         mid_ff <= mid_in;
         out_ff <= out_in;
         if (link_in.valid && (link_in.req.opcode == OP_CLEAR)) begin
            slot_valid_ff <= '0;
         end else if (load_here) begin
            slot_valid_ff[slot_addr] <= 1'b1;
            dest_ff[slot_addr]       <= VALUE_BITS'(link_in.req.dest_start);
            src_ff[slot_addr]        <= VALUE_BITS'(link_in.req.source_start);
            len_ff[slot_addr]        <= VALUE_BITS'(link_in.req.range_length);
         end
      end
   end

   assign link_out = out_ff;

endmodule

// File: src/crrm_min.sv
// Running minimum and the result register at the end of the chain.
module crrm_min
   import crrm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  link_type link_in,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   value_type lowest_ff, lowest_in;
   value_type mapped;
   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff;
   logic      is_query;
   logic      is_clear;

   assign mapped   = VALUE_BITS'(link_in.req.query_value);
   assign is_query = link_in.valid && (link_in.req.opcode == OP_QUERY);
   assign is_clear = link_in.valid && (link_in.req.opcode == OP_CLEAR);

   always_comb begin
      lowest_in = lowest_ff;
      if (is_clear) begin
         lowest_in = '1;
      end else if (is_query && (mapped < lowest_ff)) begin
         lowest_in = mapped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff    <= '1;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         lowest_ff    <= lowest_in;
         rsp_valid_ff <= is_query;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.mapped_value <= 32'(mapped);
         rsp_data_ff.lowest_value <= 32'(lowest_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/crrm_checker.sv
// Port-level checks for the cascaded range remap block, bound to the top level.
`include "cascaded_range_remap_min_assert.svh"

module crrm_checker
   import crrm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input req_type    req_data,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input rsp_type    rsp_data,
   input logic       csr_valid,
   input logic       csr_ready,
   input logic [3:0] csr_data
);

   `CRRM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result changed while stalled")
   `CRRM_ASSERT_NOW(a_min_bound, rsp_valid, rsp_data.lowest_value <= rsp_data.mapped_value, "lowest value above mapped value")
   `CRRM_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall, "request stalled without a stalled result")
   `CRRM_ASSERT_ALWAYS(a_reset_idle, reset, !rsp_valid && !req_stall, "result pending after reset")

endmodule

bind cascaded_range_remap_min crrm_checker u_checker (.*);
